@@ rtl/fcsd_pkg.sv @@
// Shared types, codes and constants for the flash command sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package fcsd_pkg;

  localparam int FCSD_ARRAY_WORDS  = 8192;
  localparam int FCSD_SECTOR_WORDS = 2048;

  localparam int ADDR_W    = 14;
  localparam int DATA_W    = 16;
  localparam int WORD_IN_W = ADDR_W - 1;
  localparam int TICKS_W   = 10;
  localparam int FUNC_W    = 2;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_WRITE_ENABLE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNLOCK_OFFSET_A = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNLOCK_OFFSET_B = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REGION_MASK     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PROGRAM_TICKS   = 3'd4;

  localparam logic [ADDR_W-1:0]  RST_UNLOCK_OFFSET_A = 14'd2728;
  localparam logic [ADDR_W-1:0]  RST_UNLOCK_OFFSET_B = 14'd1364;
  localparam logic [ADDR_W-1:0]  RST_REGION_MASK     = 14'd4095;
  localparam logic [TICKS_W-1:0] RST_PROGRAM_TICKS   = 10'd16;

  localparam logic [DATA_W-1:0] CMD_UNLOCK1      = 16'h00AA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK2      = 16'h0055;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 16'h00A0;
  localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 16'h0080;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 16'h0030;
  localparam logic [DATA_W-1:0] CMD_RESET        = 16'h00F0;
  localparam logic [DATA_W-1:0] ERASED_WORD      = 16'hFFFF;

  typedef enum logic [6:0] {
    CS_IDLE          = 7'b0000001,
    CS_UNLOCK1       = 7'b0000010,
    CS_UNLOCK2       = 7'b0000100,
    CS_PROG          = 7'b0001000,
    CS_ERASE_SETUP   = 7'b0010000,
    CS_ERASE_UNLOCK1 = 7'b0100000,
    CS_ERASE_UNLOCK2 = 7'b1000000
  } cmd_stage_t;

  typedef struct packed {
    cmd_stage_t stage_next;
    logic       start_prog;
    logic       start_erase;
  } cmd_dec_t;

endpackage

`default_nettype wire

@@ rtl/fcsd_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fcsd_ram import fcsd_pkg::*; #(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = FCSD_ARRAY_WORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ rtl/fcsd_cmd.sv @@
// Unlock and command sequence decoder for bus writes while the array is idle.
`timescale 1ns / 1ps
`default_nettype none

module fcsd_cmd import fcsd_pkg::*; (
  input  cmd_stage_t        stage,
  input  logic [ADDR_W-1:0] byte_addr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] unlock_offset_a,
  input  logic [ADDR_W-1:0] unlock_offset_b,
  input  logic [ADDR_W-1:0] region_mask,
  output cmd_dec_t          dec
);

  logic at_a;
  logic at_b;

  // Bit 0 of the address is ignored on both sides.
  assign at_a = (byte_addr[ADDR_W-1:1] & region_mask[ADDR_W-1:1]) ==
                unlock_offset_a[ADDR_W-1:1];
  assign at_b = (byte_addr[ADDR_W-1:1] & region_mask[ADDR_W-1:1]) ==
                unlock_offset_b[ADDR_W-1:1];

  always_comb begin
    dec.stage_next  = CS_IDLE;
    dec.start_prog  = 1'b0;
    dec.start_erase = 1'b0;
    // Reset command drops any partial sequence, except as program data.
    if (!(wdata == CMD_RESET && stage != CS_PROG)) begin
      case (stage)
        CS_IDLE: begin
          if (wdata == CMD_UNLOCK1 && at_a) dec.stage_next = CS_UNLOCK1;
        end
        CS_UNLOCK1: begin
          if (wdata == CMD_UNLOCK2 && at_b) dec.stage_next = CS_UNLOCK2;
        end
        CS_UNLOCK2: begin
          if (at_a && wdata == CMD_PROGRAM) begin
            dec.stage_next = CS_PROG;
          end else if (at_a && wdata == CMD_ERASE_SETUP) begin
            dec.stage_next = CS_ERASE_SETUP;
          end
        end
        CS_PROG: begin
          dec.start_prog = 1'b1;
        end
        CS_ERASE_SETUP: begin
          if (wdata == CMD_UNLOCK1 && at_a) dec.stage_next = CS_ERASE_UNLOCK1;
        end
        CS_ERASE_UNLOCK1: begin
          if (wdata == CMD_UNLOCK2 && at_b) dec.stage_next = CS_ERASE_UNLOCK2;
        end
        CS_ERASE_UNLOCK2: begin
          if (wdata == CMD_SECTOR_ERASE) dec.start_erase = 1'b1;
        end
        default: begin
          dec.stage_next = CS_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/flash_command_sequence_decoder.sv @@
// Flash array model with an unlock-sequence command interface.
//
// Input channel (in_valid/in_ready): func, byte_addr, wdata. func selects a
// bus read, a bus write (command decode) or one time tick. Output channel
// (out_valid/out_ready): one result per transaction with rdata, ready_res
// and failed. Registers are written through the APB port at 4*index.
//
// Timing: writes, busy reads, unused codes and most ticks load their result
// into the output register on acceptance; an idle read and the tick that
// completes a word program pass through ST_MEM first, as the array RAM has
// registered read data (read, then modify and write back). One transaction
// is in flight at a time: the short ones can follow back to back while
// out_ready keeps up, and one through ST_MEM keeps in_ready low meanwhile.
//
// Reset: the array RAM is cleared to erased words by a pass over all
// ARRAY_WORDS words, one word per cycle; in_ready stays low until it
// finishes. APB writes are taken throughout.
//
// Stall: while out_valid is high and out_ready low, no new transaction is
// accepted and the result holds.
`timescale 1ns / 1ps
`default_nettype none

module flash_command_sequence_decoder import fcsd_pkg::*; #(
  parameter int ARRAY_WORDS  = FCSD_ARRAY_WORDS,
  parameter int SECTOR_WORDS = FCSD_SECTOR_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  func,
  input  logic [ADDR_W-1:0]  byte_addr,
  input  logic [DATA_W-1:0]  wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  rdata,
  output logic               ready_res,
  output logic               failed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW        = $clog2(ARRAY_WORDS);
  localparam int SW        = $clog2(SECTOR_WORDS);
  localparam int WordSpan  = 1 << WORD_IN_W;
  localparam int ModSteps  = (WordSpan + ARRAY_WORDS - 1) / ARRAY_WORDS;
  localparam int NumSec    = (WordSpan + SECTOR_WORDS - 1) / SECTOR_WORDS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_MEM   = 3'b100
  } state_t;

  // Configuration registers
  logic               write_enable;
  logic [ADDR_W-1:0]  unlock_offset_a;
  logic [ADDR_W-1:0]  unlock_offset_b;
  logic [ADDR_W-1:0]  region_mask;
  logic [TICKS_W-1:0] program_ticks;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // Control state
  state_t             state, state_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  cmd_stage_t         cmd_stage, cmd_stage_next;
  logic               busy, busy_next;
  logic               op_is_erase, op_is_erase_next;
  logic [TICKS_W-1:0] prog_count, prog_count_next;
  logic               toggle_bit, toggle_bit_next;
  logic               fail_flag, fail_flag_next;
  logic [AW-1:0]      target_word, target_word_next;
  logic [DATA_W-1:0]  target_data, target_data_next;
  logic [SW-1:0]      sec_count, sec_count_next;
  logic               mem_is_prog, mem_is_prog_next;

  logic               accept;
  logic               out_load;
  logic [DATA_W-1:0]  out_rdata;
  logic [DATA_W-1:0]  status_word;
  logic               erase_last;

  logic [WORD_IN_W-1:0] word_mod;
  logic [AW-1:0]        word;
  logic [AW-1:0]        sector_base;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  cmd_dec_t dec;

  // ---------------------------------------------------------------- APB port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_enable    <= 1'b0;
      unlock_offset_a <= RST_UNLOCK_OFFSET_A;
      unlock_offset_b <= RST_UNLOCK_OFFSET_B;
      region_mask     <= RST_REGION_MASK;
      program_ticks   <= RST_PROGRAM_TICKS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WRITE_ENABLE:    write_enable    <= pwdata[0];
        REG_UNLOCK_OFFSET_A: unlock_offset_a <= pwdata[ADDR_W-1:0];
        REG_UNLOCK_OFFSET_B: unlock_offset_b <= pwdata[ADDR_W-1:0];
        REG_REGION_MASK:     region_mask     <= pwdata[ADDR_W-1:0];
        REG_PROGRAM_TICKS:   program_ticks   <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WRITE_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, write_enable};
      REG_UNLOCK_OFFSET_A: prdata = {{(PDATA_W-ADDR_W){1'b0}}, unlock_offset_a};
      REG_UNLOCK_OFFSET_B: prdata = {{(PDATA_W-ADDR_W){1'b0}}, unlock_offset_b};
      REG_REGION_MASK:     prdata = {{(PDATA_W-ADDR_W){1'b0}}, region_mask};
      REG_PROGRAM_TICKS:   prdata = {{(PDATA_W-TICKS_W){1'b0}}, program_ticks};
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------- address mapping
  always_comb begin
    word_mod = byte_addr[ADDR_W-1:1];
    for (int i = 0; i < ModSteps; i++) begin
      if (32'(word_mod) >= 32'(ARRAY_WORDS)) begin
        word_mod = word_mod - WORD_IN_W'(ARRAY_WORDS);
      end
    end
  end

  assign word = AW'(word_mod);

  // Highest sector start at or below the word
  always_comb begin
    sector_base = '0;
    for (int k = 0; k < NumSec; k++) begin
      if (32'(word_mod) >= 32'(k * SECTOR_WORDS)) begin
        sector_base = AW'(k * SECTOR_WORDS);
      end
    end
  end

  fcsd_cmd u_cmd (
    .stage           (cmd_stage),
    .byte_addr       (byte_addr),
    .wdata           (wdata),
    .unlock_offset_a (unlock_offset_a),
    .unlock_offset_b (unlock_offset_b),
    .region_mask     (region_mask),
    .dec             (dec)
  );

  fcsd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ARRAY_WORDS)
  ) u_array (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- control
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign status_word = {8'd0, (op_is_erase ? 1'b0 : ~target_data[7]),
                        toggle_bit, fail_flag, 5'd0};

  assign erase_last = (sec_count == SW'(SECTOR_WORDS - 1)) ||
                      (target_word == AW'(ARRAY_WORDS - 1));

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    cmd_stage_next   = cmd_stage;
    busy_next        = busy;
    op_is_erase_next = op_is_erase;
    prog_count_next  = prog_count;
    toggle_bit_next  = toggle_bit;
    fail_flag_next   = fail_flag;
    target_word_next = target_word;
    target_data_next = target_data;
    sec_count_next   = sec_count;
    mem_is_prog_next = mem_is_prog;
    out_load         = 1'b0;
    out_rdata        = '0;
    ram_we           = 1'b0;
    ram_addr         = word;
    ram_wdata        = ERASED_WORD;

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_addr      = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(ARRAY_WORDS - 1)) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (func)
            FUNC_READ: begin
              if (busy) begin
                out_rdata       = status_word;
                toggle_bit_next = ~toggle_bit;
              end else begin
                // Fetch the word; the result is loaded in ST_MEM
                out_load         = 1'b0;
                ram_addr         = word;
                mem_is_prog_next = 1'b0;
                state_next       = ST_MEM;
              end
            end

            FUNC_WRITE: begin
              if (write_enable) begin
                if (busy) begin
                  if (fail_flag && wdata == CMD_RESET) begin
                    fail_flag_next = 1'b0;
                    busy_next      = 1'b0;
                    cmd_stage_next = CS_IDLE;
                  end
                end else begin
                  cmd_stage_next = dec.stage_next;
                  if (dec.start_prog) begin
                    target_word_next = word;
                    target_data_next = wdata;
                    busy_next        = 1'b1;
                    op_is_erase_next = 1'b0;
                    prog_count_next  = (program_ticks == '0) ? TICKS_W'(1) : program_ticks;
                  end
                  if (dec.start_erase) begin
                    target_word_next = sector_base;
                    busy_next        = 1'b1;
                    op_is_erase_next = 1'b1;
                    sec_count_next   = '0;
                  end
                end
              end
            end

            FUNC_TICK: begin
              if (busy && !fail_flag) begin
                if (op_is_erase) begin
                  ram_we           = 1'b1;
                  ram_addr         = target_word;
                  target_word_next = target_word + AW'(1);
                  sec_count_next   = sec_count + SW'(1);
                  if (erase_last) busy_next = 1'b0;
                end else if (prog_count > TICKS_W'(1)) begin
                  prog_count_next = prog_count - TICKS_W'(1);
                end else begin
                  // Program completes: read the old word, merge next cycle
                  prog_count_next  = '0;
                  out_load         = 1'b0;
                  ram_addr         = target_word;
                  mem_is_prog_next = 1'b1;
                  state_next       = ST_MEM;
                end
              end
            end

            default: ;
          endcase
        end
      end

      ST_MEM: begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
        if (mem_is_prog) begin
          ram_we    = 1'b1;
          ram_addr  = target_word;
          ram_wdata = ram_rdata & target_data;
          // A one over an already-programmed zero cannot be written
          if ((~ram_rdata & target_data) != '0) begin
            fail_flag_next = 1'b1;
          end else begin
            busy_next = 1'b0;
          end
        end else begin
          out_rdata = ram_rdata;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      cmd_stage   <= CS_IDLE;
      busy        <= 1'b0;
      op_is_erase <= 1'b0;
      prog_count  <= '0;
      toggle_bit  <= 1'b0;
      fail_flag   <= 1'b0;
      target_word <= '0;
      target_data <= '0;
      sec_count   <= '0;
      mem_is_prog <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      cmd_stage   <= cmd_stage_next;
      busy        <= busy_next;
      op_is_erase <= op_is_erase_next;
      prog_count  <= prog_count_next;
      toggle_bit  <= toggle_bit_next;
      fail_flag   <= fail_flag_next;
      target_word <= target_word_next;
      target_data <= target_data_next;
      sec_count   <= sec_count_next;
      mem_is_prog <= mem_is_prog_next;
    end
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rdata     <= out_rdata;
      ready_res <= ~busy_next;
      failed    <= fail_flag_next;
    end
  end

  // --------------------------------------------------------------- checks
  a_mem_after_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MEM) |-> $past(state == ST_IDLE))
    else $error("memory cycle not preceded by an accepted transaction");

  a_fail_means_busy: assert property (@(posedge clk) disable iff (rst)
    fail_flag |-> (busy && !op_is_erase))
    else $error("fail flag set outside a busy program");

  a_busy_stage_idle: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cmd_stage == CS_IDLE))
    else $error("command sequence advanced while busy");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!in_ready && !out_valid))
    else $error("transaction activity during array clear");

endmodule

`default_nettype wire

@@ tb/sv/tb_flash_command_sequence_decoder.sv @@
// Self-checking testbench for the flash command sequence decoder.
`timescale 1ns / 1ps

module tb_flash_command_sequence_decoder import fcsd_pkg::*;;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int POOL_SIZE   = 12;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              ready_res;
    logic              failed;
  } flash_resp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  func = FUNC_READ;
  logic [ADDR_W-1:0]  byte_addr = '0;
  logic [DATA_W-1:0]  wdata = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  rdata;
  logic               ready_res;
  logic               failed;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  flash_command_sequence_decoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .byte_addr(byte_addr), .wdata(wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .rdata(rdata), .ready_res(ready_res), .failed(failed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Flash behavior: array contents, command sequencer and busy status.
  logic [DATA_W-1:0]  flash_words [FCSD_ARRAY_WORDS];
  cmd_stage_t         seq_stage = CS_IDLE;
  logic               flash_busy = 1'b0;
  logic               erasing = 1'b0;
  int                 prog_wait = 0;
  logic               status_toggle = 1'b0;
  logic               prog_failed = 1'b0;
  int                 tgt_word = 0;
  logic [DATA_W-1:0]  tgt_data = '0;

  logic               cfg_we = 1'b0;
  logic [ADDR_W-1:0]  cfg_off_a = RST_UNLOCK_OFFSET_A;
  logic [ADDR_W-1:0]  cfg_off_b = RST_UNLOCK_OFFSET_B;
  logic [ADDR_W-1:0]  cfg_mask = RST_REGION_MASK;
  logic [TICKS_W-1:0] cfg_ticks = RST_PROGRAM_TICKS;

  bus_op_t            pend_q [$];
  flash_resp_t        expected_resp_q [$];
  logic [WORD_IN_W-1:0] pool_words [POOL_SIZE];

  int sent_count = 0;
  int accepted_count = 0;
  int resp_seen = 0;
  int bulk_items = 0;
  int mismatches = 0;
  int prog_count = 0;
  int fail_count = 0;
  int erase_count = 0;
  int erases_left = 2;
  int cycle_count = 0;

  logic    in_taken = 1'b0;
  logic    in_calm = 1'b0;
  logic    out_calm = 1'b0;
  int      in_gap = 0;
  int      out_stall = 0;
  bus_op_t cur_op;
  bus_op_t seen_op;
  flash_resp_t want;

  function automatic logic unlock_hit(input logic [ADDR_W-1:0] a,
                                      input logic [ADDR_W-1:0] off);
    return ((a & cfg_mask) & 14'h3FFE) == (off & 14'h3FFE);
  endfunction

  function automatic void flash_write(input logic [ADDR_W-1:0] a,
                                      input logic [DATA_W-1:0] d);
    cmd_stage_t prev;
    prev = seq_stage;
    seq_stage = CS_IDLE;
    if (flash_busy) begin
      // only a reset command after a failure gets through while busy
      if (prog_failed && d == CMD_RESET) begin
        prog_failed = 1'b0;
        flash_busy = 1'b0;
      end else begin
        seq_stage = prev;
      end
      return;
    end
    if (d == CMD_RESET && prev != CS_PROG) return;
    case (prev)
      CS_IDLE: begin
        if (d == CMD_UNLOCK1 && unlock_hit(a, cfg_off_a)) seq_stage = CS_UNLOCK1;
      end
      CS_ERASE_SETUP: begin
        if (d == CMD_UNLOCK1 && unlock_hit(a, cfg_off_a)) seq_stage = CS_ERASE_UNLOCK1;
      end
      CS_UNLOCK1: begin
        if (d == CMD_UNLOCK2 && unlock_hit(a, cfg_off_b)) seq_stage = CS_UNLOCK2;
      end
      CS_ERASE_UNLOCK1: begin
        if (d == CMD_UNLOCK2 && unlock_hit(a, cfg_off_b)) seq_stage = CS_ERASE_UNLOCK2;
      end
      CS_UNLOCK2: begin
        if (unlock_hit(a, cfg_off_a)) begin
          if (d == CMD_PROGRAM) seq_stage = CS_PROG;
          else if (d == CMD_ERASE_SETUP) seq_stage = CS_ERASE_SETUP;
        end
      end
      CS_PROG: begin
        tgt_word = int'(a[ADDR_W-1:1]);
        tgt_data = d;
        flash_busy = 1'b1;
        erasing = 1'b0;
        prog_wait = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
      end
      CS_ERASE_UNLOCK2: begin
        if (d == CMD_SECTOR_ERASE) begin
          tgt_word = (int'(a[ADDR_W-1:1]) / FCSD_SECTOR_WORDS) * FCSD_SECTOR_WORDS;
          flash_busy = 1'b1;
          erasing = 1'b1;
          prog_wait = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flash_tick();
    logic [DATA_W-1:0] old;
    if (!flash_busy || prog_failed) return;
    if (erasing) begin
      if (tgt_word < FCSD_ARRAY_WORDS) flash_words[tgt_word] = ERASED_WORD;
      tgt_word++;
      if (tgt_word >= FCSD_ARRAY_WORDS || tgt_word % FCSD_SECTOR_WORDS == 0) begin
        flash_busy = 1'b0;
        erase_count++;
      end
      return;
    end
    if (prog_wait > 1) begin
      prog_wait--;
      return;
    end
    prog_wait = 0;
    old = flash_words[tgt_word];
    flash_words[tgt_word] = old & tgt_data;
    // a one over a programmed zero cannot be written: hold busy until reset
    if ((~old & tgt_data) != '0) begin
      prog_failed = 1'b1;
      fail_count++;
      return;
    end
    flash_busy = 1'b0;
    prog_count++;
  endfunction

  function automatic flash_resp_t flash_step(input bus_op_t op);
    flash_resp_t r;
    r.rdata = '0;
    case (op.fn)
      FUNC_READ: begin
        if (flash_busy) begin
          r.rdata = {8'h00, erasing ? 1'b0 : ~tgt_data[7], status_toggle, prog_failed, 5'b0};
          status_toggle = !status_toggle;
        end else begin
          r.rdata = flash_words[op.addr[ADDR_W-1:1]];
        end
      end
      FUNC_WRITE: if (cfg_we) flash_write(op.addr, op.data);
      FUNC_TICK: flash_tick();
      default: ;
    endcase
    r.ready_res = !flash_busy;
    r.failed = prog_failed;
    return r;
  endfunction

  function automatic int pick_gap(input logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 6);
  endfunction

  // Input driver: present the next transaction once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        cur_op = pend_q.pop_front();
        in_valid <= 1'b1;
        func <= cur_op.fn;
        byte_addr <= cur_op.addr;
        wdata <= cur_op.data;
        in_gap = pick_gap(in_calm);
        if ($urandom_range(127) == 0) in_calm = !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure.
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(3) == 0) out_stall = pick_gap(out_calm);
    end
    if ($urandom_range(255) == 0) out_calm = !out_calm;
  end

  // Monitor: check results in order, predict on every accepted transaction.
  always @(posedge clk) begin
    in_taken = in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (expected_resp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: rdata %h ready_res %b failed %b",
                   rdata, ready_res, failed);
      end else begin
        want = expected_resp_q.pop_front();
        if (rdata !== want.rdata || ready_res !== want.ready_res ||
            failed !== want.failed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: rdata exp %h got %h, ready_res exp %b got %b, %s%b got %b",
                     resp_seen, want.rdata, rdata, want.ready_res, ready_res,
                     "failed exp ", want.failed, failed);
        end
        resp_seen++;
      end
    end
    if (in_taken) begin
      seen_op.fn = func;
      seen_op.addr = byte_addr;
      seen_op.data = wdata;
      expected_resp_q.push_back(flash_step(seen_op));
      accepted_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_resp_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_quiet();
    while (accepted_count != sent_count || expected_resp_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    wait_quiet();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WRITE_ENABLE:    cfg_we = val[0];
      REG_UNLOCK_OFFSET_A: cfg_off_a = val[ADDR_W-1:0];
      REG_UNLOCK_OFFSET_B: cfg_off_b = val[ADDR_W-1:0];
      REG_REGION_MASK:     cfg_mask = val[ADDR_W-1:0];
      REG_PROGRAM_TICKS:   cfg_ticks = val[TICKS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void push_op(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] a,
                                  input logic [DATA_W-1:0] d);
    bus_op_t op;
    op.fn = fn;
    op.addr = a;
    op.data = d;
    pend_q.push_back(op);
    sent_count++;
  endfunction

  // Address that matches an unlock offset under the current mask, if one can.
  function automatic logic [ADDR_W-1:0] hit_addr(input logic [ADDR_W-1:0] off);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'($urandom);
    return (off & cfg_mask & 14'h3FFE) | (r & ~cfg_mask) | (r & 14'h0001);
  endfunction

  function automatic logic [ADDR_W-1:0] pool_addr();
    return {pool_words[$urandom_range(POOL_SIZE - 1)], 1'($urandom)};
  endfunction

  function automatic logic [DATA_W-1:0] pick_cmd();
    case ($urandom_range(5))
      0: return CMD_UNLOCK1;
      1: return CMD_UNLOCK2;
      2: return CMD_PROGRAM;
      3: return CMD_ERASE_SETUP;
      4: return CMD_SECTOR_ERASE;
      default: return CMD_RESET;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return DATA_W'($urandom) | DATA_W'($urandom);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // One command write; the step named bad is replaced by a stray write.
  function automatic void push_seq(input int step, input int bad, input logic [ADDR_W-1:0] a,
                                   input logic [DATA_W-1:0] d);
    if (step == bad)
      push_op(FUNC_WRITE, $urandom_range(1) ? a : ADDR_W'($urandom),
              $urandom_range(1) ? pick_cmd() : DATA_W'($urandom));
    else
      push_op(FUNC_WRITE, a, d);
  endfunction

  function automatic void queue_program(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                                        input int bad);
    push_seq(0, bad, hit_addr(cfg_off_a), CMD_UNLOCK1);
    push_seq(1, bad, hit_addr(cfg_off_b), CMD_UNLOCK2);
    push_seq(2, bad, hit_addr(cfg_off_a), CMD_PROGRAM);
    push_seq(3, bad, a, d);
  endfunction

  function automatic void queue_erase(input logic [ADDR_W-1:0] a, input int bad);
    push_seq(0, bad, hit_addr(cfg_off_a), CMD_UNLOCK1);
    push_seq(1, bad, hit_addr(cfg_off_b), CMD_UNLOCK2);
    push_seq(2, bad, hit_addr(cfg_off_a), CMD_ERASE_SETUP);
    push_seq(3, bad, hit_addr(cfg_off_a), CMD_UNLOCK1);
    push_seq(4, bad, hit_addr(cfg_off_b), CMD_UNLOCK2);
    push_seq(5, bad, a, CMD_SECTOR_ERASE);
  endfunction

  // Ticks with a status or array read mixed in now and then.
  function automatic void queue_ticks(input int n, input int read_div);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(read_div - 1) == 0) push_op(FUNC_READ, pool_addr(), DATA_W'($urandom));
      push_op(FUNC_TICK, ADDR_W'($urandom), DATA_W'($urandom));
    end
  endfunction

  // Tick a running program or erase to its end; these ticks are not counted as stimulus.
  task automatic drain_busy();
    int n;
    int start;
    wait_quiet();
    if (flash_busy && !prog_failed) begin
      if (erasing) begin
        n = FCSD_SECTOR_WORDS - (tgt_word % FCSD_SECTOR_WORDS);
        if (FCSD_ARRAY_WORDS - tgt_word < n) n = FCSD_ARRAY_WORDS - tgt_word;
      end else begin
        n = prog_wait;
      end
      start = sent_count;
      queue_ticks(n, 64);
      bulk_items += sent_count - start;
      wait_quiet();
    end
  endtask

  task automatic run_random(input int quota);
    int i;
    int r;
    int n;
    int start;
    int bulk0;
    start = sent_count;
    bulk0 = bulk_items;
    for (i = 0; i < POOL_SIZE; i++) pool_words[i] = WORD_IN_W'($urandom);
    while ((sent_count - start) - (bulk_items - bulk0) < quota) begin
      r = $urandom_range(99);
      if (r < 45) begin
        queue_program(pool_addr(), pick_data(),
                      ($urandom_range(9) == 0) ? $urandom_range(3) : -1);
        n = ((cfg_ticks == 0) ? 1 : cfg_ticks) + $urandom_range(2) - 1;
        queue_ticks(n, 5);
        if ($urandom_range(1)) push_op(FUNC_WRITE, ADDR_W'($urandom), CMD_RESET);
      end else if (r < 48 && erases_left > 0) begin
        queue_erase(ADDR_W'($urandom), -1);
        drain_busy();
        erases_left--;
      end else if (r < 56) begin
        queue_erase(ADDR_W'($urandom), $urandom_range(5));
      end else if (r < 73) begin
        push_op(FUNC_READ, $urandom_range(9) < 7 ? pool_addr() : ADDR_W'($urandom),
                DATA_W'($urandom));
      end else if (r < 88) begin
        case ($urandom_range(2))
          0: n = int'(hit_addr(cfg_off_a));
          1: n = int'(hit_addr(cfg_off_b));
          default: n = $urandom_range(16383);
        endcase
        push_op(FUNC_WRITE, ADDR_W'(n), $urandom_range(1) ? pick_cmd() : DATA_W'($urandom));
      end else if (r < 95) begin
        push_op(FUNC_TICK, ADDR_W'($urandom), DATA_W'($urandom));
      end else begin
        push_op(FUNC_UNUSED, ADDR_W'($urandom), DATA_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < FCSD_ARRAY_WORDS; i++) flash_words[i] = ERASED_WORD;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // writes are dropped while write enable is off
    push_op(FUNC_WRITE, RST_UNLOCK_OFFSET_A, CMD_UNLOCK1);
    push_op(FUNC_READ, 14'h3FFF, 16'hFFFF);
    push_op(FUNC_UNUSED, 14'h3FFF, 16'hFFFF);
    push_op(FUNC_READ, 14'h0000, 16'h0000);
    cfg_write(REG_WRITE_ENABLE, 32'd1);
    cfg_write(REG_PROGRAM_TICKS, 32'd1);

    // reset code used as program data, status reads while busy
    queue_program(14'h0002, CMD_RESET, -1);
    push_op(FUNC_READ, 14'h0002, 16'h0000);
    push_op(FUNC_READ, 14'h0002, 16'hFFFF);
    push_op(FUNC_TICK, 14'h0000, 16'h0000);
    push_op(FUNC_READ, 14'h0003, 16'h0000);
    // program a one over a zero: fail, ignored writes and ticks, then reset
    queue_program(14'h0002, 16'h0F00, -1);
    push_op(FUNC_TICK, 14'h3FFF, 16'hFFFF);
    push_op(FUNC_READ, 14'h0002, 16'h0000);
    push_op(FUNC_WRITE, hit_addr(cfg_off_a), CMD_UNLOCK1);
    push_op(FUNC_TICK, 14'h0000, 16'h0000);
    push_op(FUNC_WRITE, 14'h0000, CMD_RESET);
    push_op(FUNC_READ, 14'h0002, 16'h0000);
    // erase of the last sector runs to the array end
    queue_erase(14'h3FFE, -1);
    drain_busy();
    push_op(FUNC_READ, 14'h3FFE, 16'h0000);
    push_op(FUNC_READ, 14'h0002, 16'h0000);

    cfg_write(REG_PROGRAM_TICKS, 32'd3);
    run_random(90);

    cfg_write(REG_REGION_MASK, 32'h3FFF);
    cfg_write(REG_UNLOCK_OFFSET_A, 32'h3FFF);
    cfg_write(REG_UNLOCK_OFFSET_B, 32'h0000);
    cfg_write(REG_PROGRAM_TICKS, 32'd1);
    run_random(90);

    // an empty mask lets every address match
    cfg_write(REG_REGION_MASK, 32'h0000);
    cfg_write(REG_UNLOCK_OFFSET_A, 32'h0000);
    cfg_write(REG_PROGRAM_TICKS, 32'd0);
    run_random(90);

    // longest program time, once
    cfg_write(REG_PROGRAM_TICKS, 32'd1023);
    drain_busy();
    if (prog_failed) push_op(FUNC_WRITE, ADDR_W'($urandom), CMD_RESET);
    queue_program(ADDR_W'($urandom), pick_data(), -1);
    drain_busy();
    if (prog_failed) push_op(FUNC_WRITE, ADDR_W'($urandom), CMD_RESET);

    m = ADDR_W'($urandom_range(16383));
    cfg_write(REG_REGION_MASK, 32'(m));
    cfg_write(REG_UNLOCK_OFFSET_A, $urandom & 32'(m));
    cfg_write(REG_UNLOCK_OFFSET_B, $urandom & 32'(m));
    cfg_write(REG_PROGRAM_TICKS, $urandom_range(8, 1));
    run_random(90);

    cfg_write(REG_WRITE_ENABLE, 32'd0);
    run_random(30);
    cfg_write(REG_WRITE_ENABLE, 32'd1);
    cfg_write(REG_REGION_MASK, $urandom_range(16383));
    cfg_write(REG_UNLOCK_OFFSET_A, $urandom_range(16383));
    cfg_write(REG_UNLOCK_OFFSET_B, $urandom_range(16383));
    run_random(60);

    wait_quiet();
    repeat (8) @(posedge clk);
    mismatches += expected_resp_q.size();
    $display("checked %0d transactions over %0d cycles, %0d mismatches", resp_seen,
             cycle_count, mismatches);
    $display("programs completed %0d, programs failed %0d, sector erases %0d",
             prog_count, fail_count, erase_count);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
